### design/idts_pkg.sv
// ----------------------------------------------------------------------------
// idts_pkg
// Shared types and constants for the indentation stack token block.
// ----------------------------------------------------------------------------
package idts_pkg;

   localparam int COL_W             = 16;
   localparam int STACK_DEPTH_DEF   = 32;

   typedef enum logic [1:0] {
      TOK_NEWLINE = 2'd0,
      TOK_INDENT  = 2'd1,
      TOK_DEDENT  = 2'd2
   } tok_kind_type;

   typedef struct packed {
      logic [COL_W-1:0] content_column;
      logic             newline_skipped;
      logic             at_end;
      logic             want_newline;
      logic             want_indent;
      logic             want_dedent;
   } req_type;

   typedef struct packed {
      logic         token_given;
      tok_kind_type token_kind;
      logic         stack_overflow;
   } rsp_type;

   // stack operation requested by the decision logic
   typedef struct packed {
      logic             push;
      logic             pop;
      logic [COL_W-1:0] push_col;
   } stk_op_type;

   // what the stack shows of itself
   typedef struct packed {
      logic [COL_W-1:0] top;
      logic             full;
   } stk_stat_type;

endpackage

### design/idts_stack.sv
// ----------------------------------------------------------------------------
// idts_stack
// Indentation column stack: top entry in a register, the rest in a
// synchronous memory. The entry below the top is read every cycle for the
// level count that takes effect at that edge, so a pop can follow any op.
// ----------------------------------------------------------------------------
module idts_stack #(
   parameter int STACK_DEPTH = idts_pkg::STACK_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  idts_pkg::stk_op_type op,
   output idts_pkg::stk_stat_type stat
);
   import idts_pkg::*;

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   logic [COL_W-1:0]  mem [STACK_DEPTH];
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [COL_W-1:0]  top_ff, top_in;
   logic [COL_W-1:0]  rd_data_ff;
   logic              sec_bottom_ff, sec_bottom_in;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [COL_W-1:0]  second;

   // bottom entry is the constant 0 and never lives in memory
   assign second = sec_bottom_ff ? '0 : rd_data_ff;

   always_comb begin
      cnt_in = cnt_ff;
      top_in = top_ff;
      if (op.push) begin
         cnt_in = cnt_ff + CNT_W'(1);
         top_in = op.push_col;
      end else if (op.pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
         top_in = second;
      end
   end

   assign rd_addr       = ADDR_W'(cnt_in - CNT_W'(2));
   assign sec_bottom_in = (cnt_in <= CNT_W'(2));
   assign wr_addr       = cnt_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= CNT_W'(1);
         top_ff        <= '0;
         sec_bottom_ff <= 1'b1;
      end else begin
         cnt_ff        <= cnt_in;
         top_ff        <= top_in;
         sec_bottom_ff <= sec_bottom_in;
      end
   end

   // write address is the old count, read address is new count minus two:
   // they never meet in one cycle
   always_ff @(posedge clock) begin
      if (op.push) begin
         mem[wr_addr] <= op.push_col;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign stat.top  = top_ff;
   assign stat.full = (cnt_ff == CNT_W'(STACK_DEPTH));

endmodule

### design/indent_dedent_token_stack_core.sv
// A response appears on rsp_valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless stalled; the column compare uses
// the top register; the entry below is read from stack memory every cycle.
// Reset: level count 1, top column 0, end-of-input newline flag clear.
// The stack memory holds no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
// indent_dedent_token_stack_core
// Turns token requests into INDENT / DEDENT / NEWLINE answers using a stack
// of indentation columns.
// ----------------------------------------------------------------------------
module indent_dedent_token_stack_core #(
   parameter int STACK_DEPTH = idts_pkg::STACK_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  idts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output idts_pkg::rsp_type rsp_data
);
   import idts_pkg::*;

   logic         accept;
   logic         rsp_valid_ff;
   rsp_type      rsp_data_ff, rsp_data_in;
   logic         end_given_ff, end_given_in;
   stk_op_type   op;
   stk_stat_type stat;

   logic [COL_W-1:0] col;
   logic             any_want;
   logic             crossed;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   idts_stack #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock(clock),
      .reset(reset),
      .op   (op),
      .stat (stat)
   );

   always_comb begin
      col      = req_data.at_end ? '0 : req_data.content_column;
      any_want = req_data.want_newline || req_data.want_indent || req_data.want_dedent;
      crossed  = req_data.newline_skipped || (req_data.at_end && !end_given_ff);

      rsp_data_in.token_given    = 1'b0;
      rsp_data_in.token_kind     = TOK_NEWLINE;
      rsp_data_in.stack_overflow = 1'b0;
      op.push     = 1'b0;
      op.pop      = 1'b0;
      op.push_col = col;
      end_given_in = end_given_ff;

      if (any_want) begin
         if (req_data.at_end) begin
            end_given_in = 1'b1;
         end
         if (col > stat.top && req_data.want_indent) begin
            rsp_data_in.token_given    = 1'b1;
            rsp_data_in.token_kind     = TOK_INDENT;
            rsp_data_in.stack_overflow = stat.full;
            op.push = accept && !stat.full;
         end else if (col < stat.top && req_data.want_dedent) begin
            // top above 0 means at least two levels, so a pop is always legal
            rsp_data_in.token_given = 1'b1;
            rsp_data_in.token_kind  = TOK_DEDENT;
            op.pop = accept;
         end else if (crossed && req_data.want_newline) begin
            rsp_data_in.token_given = 1'b1;
            rsp_data_in.token_kind  = TOK_NEWLINE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         end_given_ff <= 1'b0;
      end else begin
         if (accept) begin
            rsp_valid_ff <= 1'b1;
            end_given_ff <= end_given_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### design/idts_checker.sv
// ----------------------------------------------------------------------------
// idts_checker
// Port-level checks for the indentation stack token block.
// ----------------------------------------------------------------------------
module idts_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input idts_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input idts_pkg::rsp_type rsp_data
);
   import idts_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item produced no response");

   a_no_want_no_token: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_data.want_newline && !req_data.want_indent
      && !req_data.want_dedent |=> !rsp_data.token_given)
      else $error("token given with nothing wanted");

   a_ovf_is_indent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stack_overflow |->
         rsp_data.token_given && rsp_data.token_kind == TOK_INDENT)
      else $error("overflow flagged on a non-indent answer");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.token_given |->
         rsp_data.token_kind == TOK_NEWLINE && !rsp_data.stack_overflow)
      else $error("fields set without a token");

endmodule

bind indent_dedent_token_stack_core idts_checker u_idts_checker (.*);
